@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// next-cycle implication, disabled while reset is low
`define CSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

@@ src/csu_pkg.sv @@
package csu_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CHI_W      = 44;
    localparam int EXP_W      = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;
    localparam int OUT_PAD_W  = OUT_DATA_W - CHI_W - EXP_W;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_LOW  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_HIGH = 1'd1;

    // about 1.73 and 23.6 with 8 fraction bits
    localparam logic [CFG_W-1:0] ACCEPT_LOW_RST  = 24'd443;
    localparam logic [CFG_W-1:0] ACCEPT_HIGH_RST = 24'd6042;

    localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};

    // bit positions in the result tuser
    localparam int USER_ACCEPTED = 0;
    localparam int USER_ZERO_EXP = 1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/csu_div.sv @@
module csu_div #(
    parameter int DW = 40,
    parameter int VW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DW-1:0]         dividend,
    input  logic [VW-1:0]         divisor,
    output logic [DW-1:0]         quotient,
    output csu_pkg::div_status_t  status
);
    import csu_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    num_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW:0]      shifted;
    logic [VW:0]      trial;
    logic             fits;
    logic [VW-1:0]    rem_next;

    // restoring division, one quotient bit per cycle
    assign shifted  = {rem_reg, num_reg[DW-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign fits     = shifted >= {1'b0, den_reg};
    assign rem_next = fits ? trial[VW-1:0] : shifted[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift in where the dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ src/chi_square_uniformity_test_unit.sv @@
// Chi-square uniformity test. Each sample on the input stream is scaled to
// 0..SCALE_RANGE-1 and counted into one of NUM_BINS saturating bin counters held
// in a one-read one-write memory; the update is a read, increment and write back
// over two stages with a write-through bypass, so the block takes one sample every
// clock cycle while counting. The sample marked with tlast is counted and then
// starts the test: input is held off while the expected count is formed by a
// reciprocal multiply and the NUM_BINS terms are worked out one after another on
// a bit-serial divider of 2*COUNT_BITS+8 steps, each term passing through the
// read, difference, square, divider wait and add states; the terms are skipped
// when the expected count is zero. Then one result transaction is produced and
// the bins and the sample count start again from zero. The result waits in an
// output register, so counting of the next run goes on while it is not yet taken;
// the next test holds off input until that register is free. The user must write
// the acceptance bounds through the configuration port only while the block is
// idle; the block itself does not enforce this.
module chi_square_uniformity_test_unit #(
    parameter int NUM_BINS    = 10,
    parameter int SCALE_RANGE = 1000,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [csu_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [43:0] chi_square, [59:44] expected_per_bin, [63:60] zero fill
    output logic [csu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] accepted, [1] zero_expected
    output logic [csu_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [csu_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [csu_pkg::CFG_W-1:0]           cfg_data
);
    import csu_pkg::*;

    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int BIN_WIDTH = (SCALE_RANGE / NUM_BINS) > 0 ? (SCALE_RANGE / NUM_BINS) : 1;
    localparam int PROD_W    = SAMPLE_W + $clog2(SCALE_RANGE + 1);
    localparam int SCALED_W  = PROD_W - SAMPLE_W;
    localparam int DIV_W     = 2 * COUNT_BITS + FRAC_BITS;
    localparam int WIDE_W    = (DIV_W > CHI_W ? DIV_W : CHI_W) + 1;
    localparam int EXT_W     = COUNT_BITS > EXP_W ? COUNT_BITS : EXP_W;

    // expected count by reciprocal multiplication, exact for every total
    localparam int EXP_SH    = COUNT_BITS + $clog2(NUM_BINS);
    localparam int RCP_W     = COUNT_BITS + 1;
    localparam int EXP_PW    = COUNT_BITS + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << EXP_SH) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS);
    localparam logic [RCP_W-1:0] EXP_RCP = RCP_FULL[RCP_W-1:0];

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_WAIT_TERM,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t                state_reg;

    logic [CFG_W-1:0]      accept_low_reg;
    logic [CFG_W-1:0]      accept_high_reg;

    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   bin_vld_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    logic                  s2_valid_reg;
    logic [BIN_W-1:0]      s2_bin_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;

    logic [COUNT_BITS-1:0] expc_reg;
    logic [BIN_W-1:0]      bin_idx_reg;
    logic [COUNT_BITS-1:0] diff_reg;
    logic [COUNT_BITS-1:0] diff_next;
    logic [CHI_W-1:0]      term_reg;
    logic [CHI_W-1:0]      term_next;
    logic [CHI_W-1:0]      chi_reg;
    logic [CHI_W-1:0]      chi_next;

    logic                  out_valid_reg;
    logic [CHI_W-1:0]      out_chi_reg;
    logic [EXP_W-1:0]      out_exp_reg;
    logic                  out_acc_reg;
    logic                  out_zero_reg;

    logic                  in_fire;
    logic [PROD_W-1:0]     prod;
    logic [SCALED_W-1:0]   scaled;
    logic [BIN_W-1:0]      in_bin;
    logic [BIN_W-1:0]      rd_addr;
    logic                  rd_hit;
    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] bin_next;
    logic [COUNT_BITS-1:0] obs;
    logic [2*COUNT_BITS-1:0] sq;
    logic [WIDE_W-1:0]     quot_wide;
    logic [WIDE_W-1:0]     sum_wide;
    logic [EXT_W-1:0]      exp_ext;
    logic [EXP_PW-1:0]     exp_prod;
    logic [COUNT_BITS-1:0] exp_calc;
    logic                  zero_exp;
    logic                  accept_now;
    logic                  out_free;
    logic                  out_load;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [DIV_W-1:0]      div_quot;
    div_status_t           div_status;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_ACCUM);

    // bin select: highest bin boundary the scaled value has reached
    assign prod   = PROD_W'(s_axis_tdata) * PROD_W'(SCALE_RANGE);
    assign scaled = prod[PROD_W-1:SAMPLE_W];

    always_comb
    begin
        in_bin = '0;
        for (int k = 1; k < NUM_BINS; k++)
        begin
            if (int'(scaled) >= k * BIN_WIDTH)
            begin
                in_bin = BIN_W'(k);
            end
        end
    end

    assign rd_addr   = (state_reg == ST_ACCUM) ? in_bin : bin_idx_reg;
    assign rd_hit    = s2_valid_reg && (s2_bin_reg == rd_addr);
    assign old_count = rd_vld_reg ? rd_data_reg : '0;
    assign bin_next  = (old_count == {COUNT_BITS{1'b1}}) ? old_count : old_count + 1'b1;
    assign total_next = (total_reg == {COUNT_BITS{1'b1}}) ? total_reg : total_reg + 1'b1;

    assign exp_prod  = EXP_PW'(total_reg) * EXP_PW'(EXP_RCP);
    assign exp_calc  = COUNT_BITS'(exp_prod >> EXP_SH);

    assign obs       = old_count;
    assign diff_next = (obs >= expc_reg) ? obs - expc_reg : expc_reg - obs;
    assign sq        = diff_reg * diff_reg;

    assign quot_wide = WIDE_W'(div_quot);
    assign term_next = (quot_wide > WIDE_W'(CHI_MAX)) ? CHI_MAX : quot_wide[CHI_W-1:0];
    assign sum_wide  = WIDE_W'(chi_reg) + WIDE_W'(term_reg);
    assign chi_next  = (sum_wide > WIDE_W'(CHI_MAX)) ? CHI_MAX : sum_wide[CHI_W-1:0];

    assign zero_exp   = (expc_reg == '0);
    assign accept_now = !zero_exp && (chi_reg >= CHI_W'(accept_low_reg))
                        && (chi_reg <= CHI_W'(accept_high_reg));
    assign exp_ext    = EXT_W'(expc_reg);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign out_load   = (state_reg == ST_FINISH) && out_free;

    // divider for each squared deviation over the expected count
    assign div_start    = (state_reg == ST_SQUARE);
    assign div_dividend = {sq, {FRAC_BITS{1'b0}}};
    assign div_divisor  = expc_reg;

    csu_div #(
        .DW (DIV_W),
        .VW (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    // bin memory, read data registered with write-through on a same-entry hit
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            bin_mem[s2_bin_reg] <= bin_next;
        end
        if (rd_hit)
        begin
            rd_data_reg <= bin_next;
            rd_vld_reg  <= 1'b1;
        end
        else
        begin
            rd_data_reg <= bin_mem[rd_addr];
            rd_vld_reg  <= bin_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_ACCUM;
            accept_low_reg  <= ACCEPT_LOW_RST;
            accept_high_reg <= ACCEPT_HIGH_RST;
            bin_vld_reg     <= '0;
            s2_valid_reg    <= 1'b0;
            total_reg       <= '0;
            bin_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ACCEPT_LOW:  accept_low_reg  <= cfg_data;
                    REG_ACCEPT_HIGH: accept_high_reg <= cfg_data;
                    default: ;
                endcase
            end

            s2_valid_reg <= in_fire;
            if (in_fire)
            begin
                total_reg <= total_next;
            end
            if (s2_valid_reg)
            begin
                bin_vld_reg[s2_bin_reg] <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_ACCUM:
                begin
                    if (in_fire && s_axis_tlast)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    bin_idx_reg <= '0;
                    if (exp_calc == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:      state_reg <= ST_DIFF;
                ST_DIFF:      state_reg <= ST_SQUARE;
                ST_SQUARE:    state_reg <= ST_WAIT_TERM;
                ST_WAIT_TERM:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    if (bin_idx_reg == BIN_W'(NUM_BINS - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        bin_idx_reg <= bin_idx_reg + 1'b1;
                        state_reg   <= ST_READ;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        bin_vld_reg   <= '0;
                        total_reg     <= '0;
                        state_reg     <= ST_ACCUM;
                    end
                end
                default: state_reg <= ST_ACCUM;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        s2_bin_reg <= in_bin;
        if (state_reg == ST_DRAIN)
        begin
            chi_reg  <= '0;
            expc_reg <= exp_calc;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == ST_WAIT_TERM && div_status.done)
        begin
            term_reg <= term_next;
        end
        if (state_reg == ST_ADD)
        begin
            chi_reg <= chi_next;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_chi_reg  <= chi_reg;
            out_exp_reg  <= exp_ext[EXP_W-1:0];
            out_acc_reg  <= accept_now;
            out_zero_reg <= zero_exp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_exp_reg, out_chi_reg};
    assign m_axis_tuser  = {out_zero_reg, out_acc_reg};

endmodule

@@ src/csu_checker.sv @@
`include "assert_macros.svh"

module csu_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [csu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [csu_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import csu_pkg::*;

    logic out_stalled;
    logic in_last_fire;
    logic zero_result;
    logic zero_result_ok;

    assign out_stalled    = m_axis_tvalid && !m_axis_tready;
    assign in_last_fire   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign zero_result    = m_axis_tvalid && m_axis_tuser[USER_ZERO_EXP];
    assign zero_result_ok = !m_axis_tuser[USER_ACCEPTED]
                            && (m_axis_tdata[CHI_W-1:0] == '0)
                            && (m_axis_tdata[CHI_W+EXP_W-1:CHI_W] == '0);

    // a stalled result stays offered
    `CSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, m_axis_tvalid)

    // the final sample of a run holds off input while the test runs
    `CSU_ASSERT_NEXT(a_last_holds_input, clk, rst_n, in_last_fire, !s_axis_tready)

    // an empty expectation never passes and reports a zero statistic
    `CSU_ASSERT_SAME(a_zero_rejects, clk, rst_n, zero_result, zero_result_ok)

endmodule

bind chi_square_uniformity_test_unit csu_checker u_csu_checker (.*);
